@@ hdl/tcmst_pkg.sv @@
// Shared constants and the result record for the text cell mouse selection tracker.
// No dependencies. Used by tcmst_map and text_cell_mouse_selection_tracker_unit.

package tcmst_pkg;

    // Pixel size of one character cell.
    localparam int CELL_HEIGHT = 16;
    localparam int CELL_WIDTH  = 8;

    // Upper bounds on the effective console size.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 256;

    localparam int COORD_W  = 13;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 8;
    localparam int ROWCNT_W = 7;
    localparam int COLCNT_W = 9;

    localparam logic [ROWCNT_W-1:0] ROWS_RESET = ROWCNT_W'(25);
    localparam logic [COLCNT_W-1:0] COLS_RESET = COLCNT_W'(80);
    localparam logic [ROWCNT_W-1:0] ROWS_LIMIT = ROWCNT_W'(MAX_ROWS);
    localparam logic [COLCNT_W-1:0] COLS_LIMIT = COLCNT_W'(MAX_COLS);

    // Event codes.
    localparam logic [1:0] CMD_MOVE   = 2'd0;
    localparam logic [1:0] CMD_DOWN   = 2'd1;
    localparam logic [1:0] CMD_UP     = 2'd2;
    localparam logic [1:0] CMD_FORGET = 2'd3;

    // Button codes.
    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;

    // Register indexes.
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // One result; the last member lands in the lowest bits of m_tdata.
    typedef struct packed {
        logic             changed;
        logic             paste_request;
        logic             copy_request;
        logic [COL_W-1:0] stop_col;
        logic [ROW_W-1:0] stop_row;
        logic [COL_W-1:0] start_col;
        logic [ROW_W-1:0] start_row;
        logic             drag_active;
        logic             sel_valid;
        logic [COL_W-1:0] ptr_col;
        logic [ROW_W-1:0] ptr_row;
        logic             ptr_valid;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ hdl/tcmst_map.sv @@
// Maps a signed pixel position to a character cell, clamped to the console.
// Depends on tcmst_pkg.

module tcmst_map (
    input  logic [tcmst_pkg::COORD_W-1:0]  pointer_x,
    input  logic [tcmst_pkg::COORD_W-1:0]  pointer_y,
    input  logic [tcmst_pkg::ROWCNT_W-1:0] rows,
    input  logic [tcmst_pkg::COLCNT_W-1:0] cols,
    output logic [tcmst_pkg::ROW_W-1:0]    cell_row,
    output logic [tcmst_pkg::COL_W-1:0]    cell_col
);

    localparam int MAG_W = tcmst_pkg::COORD_W - 1;

    logic [MAG_W-1:0] row_q;
    logic [MAG_W-1:0] col_q;
    logic [tcmst_pkg::ROWCNT_W-1:0] rows_m1;
    logic [tcmst_pkg::COLCNT_W-1:0] cols_m1;

    // Cell sizes are powers of two, so these are shifts.
    assign row_q   = MAG_W'(pointer_y[MAG_W-1:0] / tcmst_pkg::CELL_HEIGHT);
    assign col_q   = MAG_W'(pointer_x[MAG_W-1:0] / tcmst_pkg::CELL_WIDTH);
    assign rows_m1 = rows - tcmst_pkg::ROWCNT_W'(1);
    assign cols_m1 = cols - tcmst_pkg::COLCNT_W'(1);

    always_comb begin
        if (pointer_y[MAG_W]) begin
            cell_row = '0;
        end else if (row_q >= MAG_W'(rows)) begin
            cell_row = rows_m1[tcmst_pkg::ROW_W-1:0];
        end else begin
            cell_row = row_q[tcmst_pkg::ROW_W-1:0];
        end

        if (pointer_x[MAG_W]) begin
            cell_col = '0;
        end else if (col_q >= MAG_W'(cols)) begin
            cell_col = cols_m1[tcmst_pkg::COL_W-1:0];
        end else begin
            cell_col = col_q[tcmst_pkg::COL_W-1:0];
        end
    end

endmodule

@@ hdl/text_cell_mouse_selection_tracker_unit.sv @@
// Top level of the text cell mouse selection tracker: event register, state update, result register.
// Depends on tcmst_pkg and tcmst_map.
//
//  port group  | dir | contents
//  s_*         | in  | mouse event: tuser = command, tdata = pointer_x, pointer_y, button
//  m_*         | out | one result per event: pointer, selection bounds, pulses, changed
//  p*          | in  | APB registers: row_count at 0x0, col_count at 0x4
//
// Each event passes through the event register and then the result register; a new
// event is taken every cycle while m_tready is high. The state update for an event happens
// as it moves into the result register, so the next event sees it directly.
// A stalled result holds the event register; s_tready drops only when both are full.
// aresetn clears all state and restores 25 rows by 80 columns.

module text_cell_mouse_selection_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] pointer_x, [25:13] pointer_y, [27:26] button
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] ptr_valid, [6:1] ptr_row, [14:7] ptr_col, [15] sel_valid, [16] drag_active,
    // [22:17] start_row, [30:23] start_col, [36:31] stop_row, [44:37] stop_col,
    // [45] copy_request, [46] paste_request, [47] changed
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_W = tcmst_pkg::ROW_W;
    localparam int COL_W = tcmst_pkg::COL_W;
    localparam int CW    = tcmst_pkg::COORD_W;

    // Configuration
    logic [tcmst_pkg::ROWCNT_W-1:0] row_count_reg;
    logic [tcmst_pkg::COLCNT_W-1:0] col_count_reg;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= tcmst_pkg::ROWS_RESET;
            col_count_reg <= tcmst_pkg::COLS_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == tcmst_pkg::REG_ROW_COUNT) begin
                row_count_reg <= pwdata[tcmst_pkg::ROWCNT_W-1:0];
            end else begin
                col_count_reg <= pwdata[tcmst_pkg::COLCNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == tcmst_pkg::REG_COL_COUNT) begin
            prdata = {{(32-tcmst_pkg::COLCNT_W){1'b0}}, col_count_reg};
        end else begin
            prdata = {{(32-tcmst_pkg::ROWCNT_W){1'b0}}, row_count_reg};
        end
    end

    // Event register
    logic          in_vld_reg;
    logic [1:0]    cmd_reg;
    logic [1:0]    btn_reg;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    logic          out_free;
    logic          fire;

    logic                 m_vld_reg;
    tcmst_pkg::result_t   res_reg;
    tcmst_pkg::result_t   res_next;

    assign out_free = !m_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg <= s_tuser;
            x_reg   <= s_tdata[CW-1:0];
            y_reg   <= s_tdata[2*CW-1:CW];
            btn_reg <= s_tdata[2*CW+1:2*CW];
        end
    end

    // Effective console size
    logic [tcmst_pkg::ROWCNT_W-1:0] rows_eff;
    logic [tcmst_pkg::COLCNT_W-1:0] cols_eff;
    logic [ROW_W-1:0]               cell_row;
    logic [COL_W-1:0]               cell_col;

    assign rows_eff = (row_count_reg > tcmst_pkg::ROWS_LIMIT) ? tcmst_pkg::ROWS_LIMIT
                                                              : row_count_reg;
    assign cols_eff = (col_count_reg > tcmst_pkg::COLS_LIMIT) ? tcmst_pkg::COLS_LIMIT
                                                              : col_count_reg;

    tcmst_map u_map (
        .pointer_x (x_reg),
        .pointer_y (y_reg),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .cell_row  (cell_row),
        .cell_col  (cell_col)
    );

    // Tracker state
    logic             have_ptr_reg, have_ptr_next;
    logic [ROW_W-1:0] ptr_row_reg, ptr_row_next;
    logic [COL_W-1:0] ptr_col_reg, ptr_col_next;
    logic             drag_reg, drag_next;
    logic             sel_reg, sel_next;
    logic [ROW_W-1:0] anc_row_reg, anc_row_next;
    logic [COL_W-1:0] anc_col_reg, anc_col_next;
    logic [ROW_W-1:0] end_row_reg, end_row_next;
    logic [COL_W-1:0] end_col_reg, end_col_next;

    logic active;
    logic fwd;
    logic changed;
    logic copy_req;
    logic paste_req;

    assign active = (rows_eff != '0) && (cols_eff != '0);

    always_comb begin
        have_ptr_next = have_ptr_reg;
        ptr_row_next  = ptr_row_reg;
        ptr_col_next  = ptr_col_reg;
        drag_next     = drag_reg;
        sel_next      = sel_reg;
        anc_row_next  = anc_row_reg;
        anc_col_next  = anc_col_reg;
        end_row_next  = end_row_reg;
        end_col_next  = end_col_reg;
        changed       = 1'b0;
        copy_req      = 1'b0;
        paste_req     = 1'b0;

        if (cmd_reg == tcmst_pkg::CMD_FORGET) begin
            have_ptr_next = 1'b0;
            drag_next     = 1'b0;
            sel_next      = 1'b0;
        end else if (active) begin
            case (cmd_reg)
                tcmst_pkg::CMD_MOVE: begin
                    if (!have_ptr_reg || cell_row != ptr_row_reg || cell_col != ptr_col_reg) begin
                        have_ptr_next = 1'b1;
                        ptr_row_next  = cell_row;
                        ptr_col_next  = cell_col;
                        changed       = 1'b1;
                    end
                    if (drag_reg && (cell_row != end_row_reg || cell_col != end_col_reg)) begin
                        end_row_next = cell_row;
                        end_col_next = cell_col;
                        sel_next     = (cell_row != anc_row_reg) || (cell_col != anc_col_reg);
                        changed      = 1'b1;
                    end
                end
                tcmst_pkg::CMD_DOWN: begin
                    if (btn_reg == tcmst_pkg::BTN_LEFT) begin
                        anc_row_next = cell_row;
                        anc_col_next = cell_col;
                        end_row_next = cell_row;
                        end_col_next = cell_col;
                        drag_next    = 1'b1;
                        sel_next     = 1'b0;
                        changed      = 1'b1;
                    end else if (btn_reg == tcmst_pkg::BTN_RIGHT) begin
                        paste_req = 1'b1;
                    end
                end
                tcmst_pkg::CMD_UP: begin
                    if (btn_reg == tcmst_pkg::BTN_LEFT && drag_reg) begin
                        drag_next = 1'b0;
                        copy_req  = sel_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        // Order the two ends so start is the earlier cell in reading order.
        fwd = (anc_row_next < end_row_next) ||
              (anc_row_next == end_row_next && anc_col_next <= end_col_next);

        res_next.ptr_valid     = have_ptr_next;
        res_next.ptr_row       = have_ptr_next ? ptr_row_next : '0;
        res_next.ptr_col       = have_ptr_next ? ptr_col_next : '0;
        res_next.sel_valid     = sel_next;
        res_next.drag_active   = drag_next;
        res_next.start_row     = !sel_next ? '0 : (fwd ? anc_row_next : end_row_next);
        res_next.start_col     = !sel_next ? '0 : (fwd ? anc_col_next : end_col_next);
        res_next.stop_row      = !sel_next ? '0 : (fwd ? end_row_next : anc_row_next);
        res_next.stop_col      = !sel_next ? '0 : (fwd ? end_col_next : anc_col_next);
        res_next.copy_request  = copy_req;
        res_next.paste_request = paste_req;
        res_next.changed       = changed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_ptr_reg <= 1'b0;
            ptr_row_reg  <= '0;
            ptr_col_reg  <= '0;
            drag_reg     <= 1'b0;
            sel_reg      <= 1'b0;
            anc_row_reg  <= '0;
            anc_col_reg  <= '0;
            end_row_reg  <= '0;
            end_col_reg  <= '0;
        end else if (fire) begin
            have_ptr_reg <= have_ptr_next;
            ptr_row_reg  <= ptr_row_next;
            ptr_col_reg  <= ptr_col_next;
            drag_reg     <= drag_next;
            sel_reg      <= sel_next;
            anc_row_reg  <= anc_row_next;
            anc_col_reg  <= anc_col_next;
            end_row_reg  <= end_row_next;
            end_col_reg  <= end_col_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_free) begin
            m_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = res_reg;

    // Checks
    a_copy_ends_drag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.copy_request |-> !res_reg.drag_active && res_reg.sel_valid)
        else $error("copy request with drag still active or no selection");

    a_paste_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.paste_request |-> !res_reg.changed && !res_reg.copy_request)
        else $error("paste request together with a state change");

    a_bounds_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.sel_valid |->
            (res_reg.start_row < res_reg.stop_row) ||
            (res_reg.start_row == res_reg.stop_row && res_reg.start_col < res_reg.stop_col))
        else $error("selection bounds out of order or single cell");

    a_no_sel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && !res_reg.sel_valid |->
            res_reg.start_row == '0 && res_reg.start_col == '0 &&
            res_reg.stop_row == '0 && res_reg.stop_col == '0)
        else $error("selection bounds nonzero without a selection");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(drag_reg) && $stable(sel_reg) && $stable(have_ptr_reg))
        else $error("tracker state moved without an event");

endmodule

@@ verif/selection_tracker_checker.sv @@
// Checker for the text cell mouse selection tracker: tracks register writes and accepted events,
// predicts each result and compares it with what the block returns. Depends on tcmst_pkg.

module selection_tracker_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // console size as last written
    logic [tcmst_pkg::ROWCNT_W-1:0] row_cfg;
    logic [tcmst_pkg::COLCNT_W-1:0] col_cfg;

    // tracker state
    bit                        have_ptr;
    bit [tcmst_pkg::ROW_W-1:0] ptr_r;
    bit [tcmst_pkg::COL_W-1:0] ptr_c;
    bit                        dragging;
    bit                        selecting;
    bit [tcmst_pkg::ROW_W-1:0] anc_r;
    bit [tcmst_pkg::COL_W-1:0] anc_c;
    bit [tcmst_pkg::ROW_W-1:0] end_r;
    bit [tcmst_pkg::COL_W-1:0] end_c;

    tcmst_pkg::result_t expected_results[$];
    int                 errors;

    function automatic int unsigned cell_index(logic [tcmst_pkg::COORD_W-1:0] pix,
                                               int unsigned size, int unsigned count);
        int unsigned c;
        if (pix[tcmst_pkg::COORD_W-1])
            return 0;
        c = pix / size;
        if (c >= count)
            c = count - 1;
        return c;
    endfunction

    function automatic tcmst_pkg::result_t track_event(logic [1:0] cmd,
                                                       logic [tcmst_pkg::COORD_W-1:0] px,
                                                       logic [tcmst_pkg::COORD_W-1:0] py,
                                                       logic [1:0] btn);
        tcmst_pkg::result_t r;
        int unsigned        rows;
        int unsigned        cols;
        int unsigned        row;
        int unsigned        col;
        bit                 ahead;
        r    = '0;
        rows = (row_cfg > tcmst_pkg::ROWS_LIMIT) ? tcmst_pkg::MAX_ROWS : row_cfg;
        cols = (col_cfg > tcmst_pkg::COLS_LIMIT) ? tcmst_pkg::MAX_COLS : col_cfg;
        if (cmd == tcmst_pkg::CMD_FORGET) begin
            have_ptr  = 0;
            dragging  = 0;
            selecting = 0;
        end else if (rows != 0 && cols != 0) begin
            row = cell_index(py, tcmst_pkg::CELL_HEIGHT, rows);
            col = cell_index(px, tcmst_pkg::CELL_WIDTH, cols);
            case (cmd)
                tcmst_pkg::CMD_MOVE: begin
                    if (!have_ptr || row != ptr_r || col != ptr_c) begin
                        ptr_r     = tcmst_pkg::ROW_W'(row);
                        ptr_c     = tcmst_pkg::COL_W'(col);
                        have_ptr  = 1;
                        r.changed = 1;
                    end
                    if (dragging && (row != end_r || col != end_c)) begin
                        end_r     = tcmst_pkg::ROW_W'(row);
                        end_c     = tcmst_pkg::COL_W'(col);
                        selecting = (row != anc_r || col != anc_c);
                        r.changed = 1;
                    end
                end
                tcmst_pkg::CMD_DOWN: begin
                    if (btn == tcmst_pkg::BTN_LEFT) begin
                        anc_r     = tcmst_pkg::ROW_W'(row);
                        end_r     = tcmst_pkg::ROW_W'(row);
                        anc_c     = tcmst_pkg::COL_W'(col);
                        end_c     = tcmst_pkg::COL_W'(col);
                        dragging  = 1;
                        selecting = 0;
                        r.changed = 1;
                    end else if (btn == tcmst_pkg::BTN_RIGHT) begin
                        r.paste_request = 1;
                    end
                end
                default: begin
                    if (btn == tcmst_pkg::BTN_LEFT && dragging) begin
                        dragging       = 0;
                        r.copy_request = selecting;
                    end
                end
            endcase
        end

        r.ptr_valid   = have_ptr;
        r.ptr_row     = have_ptr ? ptr_r : '0;
        r.ptr_col     = have_ptr ? ptr_c : '0;
        r.sel_valid   = selecting;
        r.drag_active = dragging;
        if (selecting) begin
            // bounds come out in reading order whichever way the drag went
            ahead       = (anc_r < end_r) || (anc_r == end_r && anc_c <= end_c);
            r.start_row = ahead ? anc_r : end_r;
            r.start_col = ahead ? anc_c : end_c;
            r.stop_row  = ahead ? end_r : anc_r;
            r.stop_col  = ahead ? end_c : anc_c;
        end
        return r;
    endfunction

    function automatic string field_diffs(tcmst_pkg::result_t want, tcmst_pkg::result_t got);
        string s;
        s = "";
        if (got.ptr_valid !== want.ptr_valid)         s = {s, " ptr_valid"};
        if (got.ptr_row !== want.ptr_row)             s = {s, " ptr_row"};
        if (got.ptr_col !== want.ptr_col)             s = {s, " ptr_col"};
        if (got.sel_valid !== want.sel_valid)         s = {s, " sel_valid"};
        if (got.drag_active !== want.drag_active)     s = {s, " drag_active"};
        if (got.start_row !== want.start_row)         s = {s, " start_row"};
        if (got.start_col !== want.start_col)         s = {s, " start_col"};
        if (got.stop_row !== want.stop_row)           s = {s, " stop_row"};
        if (got.stop_col !== want.stop_col)           s = {s, " stop_col"};
        if (got.copy_request !== want.copy_request)   s = {s, " copy_request"};
        if (got.paste_request !== want.paste_request) s = {s, " paste_request"};
        if (got.changed !== want.changed)             s = {s, " changed"};
        return s;
    endfunction

    always @(posedge aclk) begin
        tcmst_pkg::result_t want;
        tcmst_pkg::result_t got;
        string              diffs;
        if (!aresetn) begin
            row_cfg   = tcmst_pkg::ROWS_RESET;
            col_cfg   = tcmst_pkg::COLS_RESET;
            have_ptr  = 0;
            ptr_r     = '0;
            ptr_c     = '0;
            dragging  = 0;
            selecting = 0;
            anc_r     = '0;
            anc_c     = '0;
            end_r     = '0;
            end_c     = '0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == tcmst_pkg::REG_COL_COUNT)
                    col_cfg = pwdata[tcmst_pkg::COLCNT_W-1:0];
                else
                    row_cfg = pwdata[tcmst_pkg::ROWCNT_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(track_event(s_tuser, s_tdata[12:0], s_tdata[25:13],
                                                       s_tdata[27:26]));
            if (m_tvalid && m_tready) begin
                got = tcmst_pkg::result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("tb: unexpected result %h", got);
                end else begin
                    want  = expected_results.pop_front();
                    diffs = field_diffs(want, got);
                    if (diffs != "") begin
                        errors++;
                        if (errors <= 10)
                            $display("tb: mismatch on%s: expected %h, got %h", diffs, want, got);
                    end
                end
            end
        end
        mismatch_count <= errors;
        outstanding    <= expected_results.size();
    end

endmodule

@@ verif/testbench.sv @@
// Top of the testbench: clock, reset, event and register stimulus, receiver stalls, verdict.
// Depends on tcmst_pkg, text_cell_mouse_selection_tracker_unit and selection_tracker_checker.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] BTN_MIDDLE   = 2'd2;
    localparam logic [1:0] BTN_EXTRA    = 2'd3;
    localparam int         LIMIT_CYCLES = 500000;
    localparam int         HOLD_CYCLES  = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int outstanding;

    int send_idle_pct;
    int stall_pct;
    bit hold_armed;
    bit hold_done;
    int events_sent;
    int span_rows;
    int span_cols;
    int cycle_count;

    logic [tcmst_pkg::COORD_W-1:0] last_x;
    logic [tcmst_pkg::COORD_W-1:0] last_y;

    text_cell_mouse_selection_tracker_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    selection_tracker_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when armed
    initial begin
        m_tready  = 0;
        hold_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_armed && !hold_done) begin
                m_tready <= 0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic push_event(input logic [1:0] cmd, input logic [1:0] btn,
                              input logic [tcmst_pkg::COORD_W-1:0] px,
                              input logic [tcmst_pkg::COORD_W-1:0] py);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, btn, py, px};
        last_x = px;
        last_y = py;
        events_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering requests and wait until every result is back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic reg_index, input int value);
        @(negedge aclk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 3'(reg_index) << 2;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic set_console(input int rows, input int cols);
        drain_results();
        write_reg(tcmst_pkg::REG_ROW_COUNT, rows);
        write_reg(tcmst_pkg::REG_COL_COUNT, cols);
        span_rows = (rows > tcmst_pkg::MAX_ROWS) ? tcmst_pkg::MAX_ROWS : (rows == 0 ? 1 : rows);
        span_cols = (cols > tcmst_pkg::MAX_COLS) ? tcmst_pkg::MAX_COLS : (cols == 0 ? 1 : cols);
    endtask

    function automatic logic [tcmst_pkg::COORD_W-1:0] pick_coord(
        int cells, int size, logic [tcmst_pkg::COORD_W-1:0] prev);
        case ($urandom_range(0, 15))
            0: return tcmst_pkg::COORD_W'($urandom_range(0, 8191));
            1: begin
                case ($urandom_range(0, 3))
                    0: return 13'h1000;
                    1: return 13'h0fff;
                    2: return 13'h1fff;
                    default: return 13'h0000;
                endcase
            end
            2, 3: return prev + tcmst_pkg::COORD_W'($urandom_range(0, 2 * size))
                         - tcmst_pkg::COORD_W'(size);
            4: return prev;
            default: return tcmst_pkg::COORD_W'($urandom_range(0, cells * size - 1));
        endcase
    endfunction

    task automatic random_event();
        logic [1:0] cmd;
        cmd = 2'($urandom_range(0, 3));
        if (cmd == tcmst_pkg::CMD_FORGET && $urandom_range(0, 3) != 0)
            cmd = tcmst_pkg::CMD_MOVE;
        push_event(cmd, 2'($urandom_range(0, 3)),
                   pick_coord(span_cols, tcmst_pkg::CELL_WIDTH, last_x),
                   pick_coord(span_rows, tcmst_pkg::CELL_HEIGHT, last_y));
    endtask

    // left press, some moves, usually a left release
    task automatic drag_gesture();
        int moves;
        moves = $urandom_range(1, 8);
        push_event(tcmst_pkg::CMD_DOWN, tcmst_pkg::BTN_LEFT,
                   pick_coord(span_cols, tcmst_pkg::CELL_WIDTH, last_x),
                   pick_coord(span_rows, tcmst_pkg::CELL_HEIGHT, last_y));
        repeat (moves) begin
            if ($urandom_range(0, 7) == 0)
                random_event();
            else
                push_event(tcmst_pkg::CMD_MOVE, 2'($urandom_range(0, 3)),
                           pick_coord(span_cols, tcmst_pkg::CELL_WIDTH, last_x),
                           pick_coord(span_rows, tcmst_pkg::CELL_HEIGHT, last_y));
        end
        case ($urandom_range(0, 9))
            0: ;
            1: push_event(tcmst_pkg::CMD_FORGET, tcmst_pkg::BTN_LEFT, last_x, last_y);
            default: push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_LEFT,
                                pick_coord(span_cols, tcmst_pkg::CELL_WIDTH, last_x),
                                pick_coord(span_rows, tcmst_pkg::CELL_HEIGHT, last_y));
        endcase
    endtask

    task automatic run_phase(input int rows, input int cols, input int tx_pct, input int rx_pct,
                             input bit long_hold, input int count);
        int target;
        set_console(rows, cols);
        send_idle_pct = tx_pct;
        stall_pct     = rx_pct;
        if (long_hold)
            hold_armed = 1;
        target = events_sent + count;
        while (events_sent < target) begin
            if ($urandom_range(0, 9) < 7)
                drag_gesture();
            else
                random_event();
            if ($urandom_range(0, 59) == 0)
                drain_results();
        end
    endtask

    initial begin
        aresetn       = 0;
        s_tvalid      = 0;
        s_tdata       = '0;
        s_tuser       = tcmst_pkg::CMD_MOVE;
        psel          = 0;
        penable       = 0;
        pwrite        = 0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_armed    = 0;
        events_sent   = 0;
        span_rows     = 25;
        span_cols     = 80;
        last_x        = '0;
        last_y        = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1;

        // directed events on the reset-size console
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(0), 13'(0));
        // same cell again
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(7), 13'(15));
        // negatives clamp to 0
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(-4096), 13'(-4096));
        // far edge clamps
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(4095), 13'(4095));
        push_event(tcmst_pkg::CMD_DOWN, tcmst_pkg::BTN_LEFT, 13'(40), 13'(32));
        // single cell: click only
        push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_LEFT, 13'(40), 13'(32));
        push_event(tcmst_pkg::CMD_DOWN, tcmst_pkg::BTN_LEFT, 13'(40), 13'(32));
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(80), 13'(48));
        // back onto the anchor
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(41), 13'(33));
        // drag runs backward
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_LEFT, 13'(0), 13'(0));
        // copy
        push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_LEFT, 13'(0), 13'(0));
        // release with no drag
        push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_LEFT, 13'(0), 13'(0));
        // paste
        push_event(tcmst_pkg::CMD_DOWN, tcmst_pkg::BTN_RIGHT, 13'(8), 13'(16));
        push_event(tcmst_pkg::CMD_DOWN, BTN_MIDDLE, 13'(8), 13'(16));
        push_event(tcmst_pkg::CMD_UP, BTN_EXTRA, 13'(8), 13'(16));
        push_event(tcmst_pkg::CMD_MOVE, BTN_EXTRA, 13'(-1), 13'(-1));
        push_event(tcmst_pkg::CMD_FORGET, tcmst_pkg::BTN_LEFT, 13'(100), 13'(100));
        push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_LEFT, 13'(100), 13'(100));
        push_event(tcmst_pkg::CMD_DOWN, tcmst_pkg::BTN_LEFT, 13'(4095), 13'(-4096));
        push_event(tcmst_pkg::CMD_MOVE, tcmst_pkg::BTN_RIGHT, 13'(-4096), 13'(4095));
        // wrong button keeps drag
        push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_RIGHT, 13'(0), 13'(0));
        push_event(tcmst_pkg::CMD_UP, tcmst_pkg::BTN_LEFT, 13'(0), 13'(0));
        push_event(tcmst_pkg::CMD_FORGET, BTN_EXTRA, 13'(-1), 13'(-1));

        run_phase(25, 80, 0, 0, 0, 250);
        run_phase(64, 256, 84, 0, 0, 200);
        run_phase(1, 1, 0, 84, 0, 150);
        run_phase(127, 511, 18, 18, 0, 200);
        run_phase(0, 80, 0, 0, 0, 60);                              // rows zero: all but forget events ignored
        run_phase(40, 0, 18, 18, 0, 40);                            // columns zero
        run_phase($urandom_range(1, 64), $urandom_range(1, 256), 0, 18, 1, 200);
        // large console first so the held cells lie outside the shrunk one
        run_phase(64, 256, 0, 0, 0, 30);
        run_phase(3, 5, 18, 18, 0, 100);

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
